// ===== hdl/pdwm_pkg.sv =====
// Package for the per-detector windowed mean block.
// Holds field widths, register codes, payload structs and the state type.
// No dependencies.
`timescale 1ns / 1ps

package pdwm_pkg;

  localparam int DET_W      = 2;
  localparam int NUM_DET    = 4;
  localparam int POS_W      = 16;
  localparam int MEAN_W     = 16;
  localparam int ACT_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE   = 2'd0,
    CFG_WIN_LOW  = 2'd1,
    CFG_WIN_HIGH = 2'd2
  } cfg_reg_t;

  localparam logic [ACT_W-1:0]        ACTIVE_RST   = 3'd4;
  localparam logic signed [POS_W-1:0] WIN_LOW_RST  = -16'sd6400;
  localparam logic signed [POS_W-1:0] WIN_HIGH_RST = 16'sd6400;

  localparam logic AXIS_X = 1'b0;

  typedef struct packed {
    logic [DET_W-1:0]        detector_id;
    logic                    axis;
    logic signed [POS_W-1:0] position;
    logic                    event_end;
  } hit_t;

  typedef struct packed {
    logic [DET_W-1:0]         hit_detector;
    logic signed [MEAN_W-1:0] mean_x;
    logic signed [MEAN_W-1:0] mean_y;
    logic                     y_present;
    logic                     final_result;
  } res_t;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_LAST,
    ST_RD,
    ST_EVAL,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

// ===== hdl/pdwm_ifs.sv =====
// Stream interfaces for hits and results of the windowed mean block.
// Depends on pdwm_pkg for the payload structs.
`timescale 1ns / 1ps

interface pdwm_hit_if;
  import pdwm_pkg::*;
  logic valid;
  logic ready;
  hit_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pdwm_res_if;
  import pdwm_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/pdwm_mem.sv =====
// Per-detector accumulator memory, one write and one registered read port.
// Depends on pdwm_pkg for the detector count and address width.
`timescale 1ns / 1ps

module pdwm_mem #(
  parameter int WIDTH = 76
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [pdwm_pkg::DET_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       rd_en,
  input  logic [pdwm_pkg::DET_W-1:0] rd_addr,
  output logic [WIDTH-1:0]           rd_data
);
  import pdwm_pkg::*;

  logic [WIDTH-1:0] mem_r [NUM_DET];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/pdwm_div.sv =====
// Bit-serial signed divider: sum by count, truncated toward zero.
// Depends on pdwm_pkg for the result width.
`timescale 1ns / 1ps

module pdwm_div #(
  parameter int SUM_W = 27,
  parameter int CNT_W = 11
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [SUM_W-1:0]            dividend,
  input  logic [CNT_W-1:0]                   divisor,
  output logic                               done,
  output logic signed [pdwm_pkg::MEAN_W-1:0] quotient
);
  import pdwm_pkg::*;

  localparam int ITER_W = $clog2(SUM_W + 1);

  logic              busy_r;
  logic              done_r;
  logic              neg_r;
  logic [SUM_W-1:0]  acc_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  div_r;
  logic [ITER_W-1:0] iter_r;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              qbit;
  logic [MEAN_W-1:0] qmag;

  assign trial = {rem_r, acc_r[SUM_W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign qbit  = (trial >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && (iter_r == ITER_W'(1))) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r  <= dividend[SUM_W-1];
      acc_r  <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
      rem_r  <= '0;
      div_r  <= divisor;
      iter_r <= ITER_W'(SUM_W);
    end else if (busy_r) begin
      acc_r  <= {acc_r[SUM_W-2:0], qbit};
      rem_r  <= qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      iter_r <= iter_r - 1'b1;
    end
  end

  assign qmag     = acc_r[MEAN_W-1:0];
  assign quotient = neg_r ? signed'(~qmag + 1'b1) : signed'(qmag);
  assign done     = done_r;

endmodule

// ===== hdl/per_detector_windowed_mean.sv =====
// Per-detector windowed mean: hit accumulation, event drain and result output.
// A hit is registered in the input stage, then added to its detector's sums; one hit per cycle
// while accumulating. After the hit marked last: ST_LAST, then per detector ST_RD and ST_EVAL,
// plus the bit-serial dividers (ST_DIV) and ST_OUT, where a result may wait on the output, for
// an enabled detector with X hits. Hits are not taken during that drain.
// Synchronous active-low reset marks all sums and counts empty, clears result valid, loads register defaults.
`timescale 1ns / 1ps

module per_detector_windowed_mean #(
  parameter int MAX_HITS_PER_AXIS = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  pdwm_hit_if.sink                       in_hit,
  pdwm_res_if.source                     out_res,
  input  logic                           cfg_we,
  input  logic [pdwm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pdwm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pdwm_pkg::*;

  localparam int CNT_W = $clog2(MAX_HITS_PER_AXIS + 1);
  localparam int SUM_W = POS_W + CNT_W;
  localparam logic [CNT_W-1:0] CNT_LIM = CNT_W'(MAX_HITS_PER_AXIS);

  typedef struct packed {
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic [CNT_W-1:0]        cnt_x;
    logic [CNT_W-1:0]        cnt_y;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  logic [ACT_W-1:0]        active_r;
  logic signed [POS_W-1:0] win_low_r;
  logic signed [POS_W-1:0] win_high_r;

  state_t             state_r, state_nxt;
  logic [DET_W-1:0]   idx_r, idx_nxt;
  logic               in_acc;
  logic               s1_valid_r;
  hit_t               s1_hit_r;
  logic               wb_valid_r;
  logic [DET_W-1:0]   wb_addr_r;
  entry_t             wb_data_r;
  logic [NUM_DET-1:0] valid_r;
  logic [NUM_DET-1:0] xnz_r;
  logic [ENTRY_W-1:0] rd_data;
  logic               mem_rd_en;
  logic [DET_W-1:0]   mem_rd_addr;
  entry_t             cur;
  entry_t             upd;
  entry_t             rd_entry;
  logic               win_ok;
  logic               take;
  logic [NUM_DET-1:0] em;
  logic [NUM_DET-1:0] later;
  logic               final_w;
  logic               div_start;
  logic               out_load;
  logic               drain_done;
  logic               advance;
  logic               yp_r;
  logic               x_done;
  logic               y_done;
  logic signed [MEAN_W-1:0] x_mean;
  logic signed [MEAN_W-1:0] y_mean;
  logic               out_valid_r;
  res_t               out_data_r;
  res_t               res_nxt;

  function automatic logic det_on(input logic [DET_W-1:0] d);
    return (ACT_W'(d) < active_r);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= ACTIVE_RST;
      win_low_r  <= WIN_LOW_RST;
      win_high_r <= WIN_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ACTIVE:   active_r   <= cfg_wdata[ACT_W-1:0];
        CFG_WIN_LOW:  win_low_r  <= signed'(cfg_wdata);
        CFG_WIN_HIGH: win_high_r <= signed'(cfg_wdata);
        default: ;
      endcase
    end
  end

  assign in_hit.ready = (state_r == ST_ACC);
  assign in_acc       = in_hit.valid && in_hit.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_hit_r <= in_hit.data;
    end
  end

  assign mem_rd_en   = in_acc || (state_r == ST_RD);
  assign mem_rd_addr = (state_r == ST_RD) ? idx_r : in_hit.data.detector_id;

  pdwm_mem #(
    .WIDTH(ENTRY_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (take),
    .wr_addr (s1_hit_r.detector_id),
    .wr_data (upd),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (rd_data)
  );

  // The entry written on the previous edge is not yet in the read data.
  always_comb begin
    if (wb_valid_r && (wb_addr_r == s1_hit_r.detector_id)) begin
      cur = wb_data_r;
    end else if (valid_r[s1_hit_r.detector_id]) begin
      cur = entry_t'(rd_data);
    end else begin
      cur = '0;
    end
    win_ok = (s1_hit_r.position >= win_low_r) && (s1_hit_r.position <= win_high_r);
    upd    = cur;
    if (s1_hit_r.axis == AXIS_X) begin
      take      = s1_valid_r && det_on(s1_hit_r.detector_id) && win_ok && (cur.cnt_x < CNT_LIM);
      upd.sum_x = cur.sum_x + SUM_W'(s1_hit_r.position);
      upd.cnt_x = cur.cnt_x + 1'b1;
    end else begin
      take      = s1_valid_r && det_on(s1_hit_r.detector_id) && win_ok && (cur.cnt_y < CNT_LIM);
      upd.sum_y = cur.sum_y + SUM_W'(s1_hit_r.position);
      upd.cnt_y = cur.cnt_y + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_valid_r <= 1'b0;
    end else begin
      wb_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      wb_addr_r <= s1_hit_r.detector_id;
      wb_data_r <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      xnz_r   <= '0;
    end else if (drain_done) begin
      valid_r <= '0;
      xnz_r   <= '0;
    end else if (take) begin
      valid_r[s1_hit_r.detector_id] <= 1'b1;
      if (s1_hit_r.axis == AXIS_X) begin
        xnz_r[s1_hit_r.detector_id] <= 1'b1;
      end
    end
  end

  assign rd_entry = valid_r[idx_r] ? entry_t'(rd_data) : '0;

  always_comb begin
    for (int j = 0; j < NUM_DET; j++) begin
      em[j]    = xnz_r[j] && det_on(DET_W'(j));
      later[j] = (DET_W'(j) > idx_r);
    end
    final_w = ~|(em & later);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACC;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    div_start  = 1'b0;
    out_load   = 1'b0;
    drain_done = 1'b0;
    advance    = 1'b0;
    unique case (state_r)
      ST_ACC: begin
        if (in_acc && in_hit.data.event_end) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        state_nxt = ST_RD;
        idx_nxt   = '0;
      end
      ST_RD: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (em[idx_r]) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          advance = 1'b1;
        end
      end
      ST_DIV: begin
        if (x_done && y_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_res.ready) begin
          out_load = 1'b1;
          advance  = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_ACC;
      end
    endcase
    if (advance) begin
      if (idx_r == DET_W'(NUM_DET - 1)) begin
        drain_done = 1'b1;
        state_nxt  = ST_ACC;
      end else begin
        idx_nxt   = idx_r + 1'b1;
        state_nxt = ST_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      yp_r <= (rd_entry.cnt_y != '0);
    end
  end

  pdwm_div #(
    .SUM_W(SUM_W),
    .CNT_W(CNT_W)
  ) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rd_entry.sum_x),
    .divisor  (rd_entry.cnt_x),
    .done     (x_done),
    .quotient (x_mean)
  );

  pdwm_div #(
    .SUM_W(SUM_W),
    .CNT_W(CNT_W)
  ) u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rd_entry.sum_y),
    .divisor  (rd_entry.cnt_y),
    .done     (y_done),
    .quotient (y_mean)
  );

  always_comb begin
    res_nxt.hit_detector = idx_r;
    res_nxt.mean_x       = x_mean;
    res_nxt.mean_y       = yp_r ? y_mean : '0;
    res_nxt.y_present    = yp_r;
    res_nxt.final_result = final_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_res.valid = out_valid_r;
  assign out_res.data  = out_data_r;

  a_write_only_for_hits: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> (state_r == ST_ACC || state_r == ST_LAST))
    else $error("accumulator written outside hit processing");

  a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
    drain_done |=> (valid_r == '0 && xnz_r == '0))
    else $error("event state not cleared after drain");

  a_result_has_x_hits: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (xnz_r[idx_r] && det_on(idx_r)))
    else $error("result for a detector without X hits");

  a_div_restart: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> (!x_done && !y_done))
    else $error("divider done flag not cleared on start");

endmodule

// ===== sim/per_detector_windowed_mean_tb.sv =====
// Testbench for per_detector_windowed_mean: directed, register, full-rate,
// backpressure and random event tests checked against a built-in mean predictor.
// Depends on pdwm_pkg, the pdwm stream interfaces and the block itself.
`timescale 1ns / 1ps

module per_detector_windowed_mean_tb;
  import pdwm_pkg::*;

  localparam int MAX_DET      = 4;
  localparam int MAX_HITS     = 1024;
  localparam int IDLE_PCT     = 24;
  localparam int DRAIN_CYCLES = 200;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pdwm_hit_if hit_ch ();
  pdwm_res_if res_ch ();

  per_detector_windowed_mean #(
    .MAX_HITS_PER_AXIS(MAX_HITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_hit(hit_ch),
    .out_res(res_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [ACT_W-1:0] cur_active;
  int cur_lo;
  int cur_hi;
  longint x_sum[MAX_DET];
  longint y_sum[MAX_DET];
  int x_cnt[MAX_DET];
  int y_cnt[MAX_DET];
  res_t pending_means[$];
  int fail_count = 0;
  bit full_rate = 1'b0;
  int sink_hold = 0;

  function automatic void clear_sums();
    for (int d = 0; d < MAX_DET; d++) begin
      x_sum[d] = 0;
      y_sum[d] = 0;
      x_cnt[d] = 0;
      y_cnt[d] = 0;
    end
  endfunction

  function automatic int active_count();
    return (cur_active > MAX_DET) ? MAX_DET : int'(cur_active);
  endfunction

  function automatic void accumulate_hit(hit_t h);
    int eff;
    int p;
    longint q;
    res_t r;
    res_t batch[$];
    eff = active_count();
    p = $signed(h.position);
    if (h.detector_id < eff && p >= cur_lo && p <= cur_hi) begin
      if (h.axis == AXIS_X) begin
        if (x_cnt[h.detector_id] < MAX_HITS) begin
          x_sum[h.detector_id] += p;
          x_cnt[h.detector_id]++;
        end
      end else begin
        if (y_cnt[h.detector_id] < MAX_HITS) begin
          y_sum[h.detector_id] += p;
          y_cnt[h.detector_id]++;
        end
      end
    end
    if (!h.event_end) return;
    for (int d = 0; d < eff; d++) begin
      if (x_cnt[d] != 0) begin
        r = '0;
        r.hit_detector = d[DET_W-1:0];
        q = x_sum[d] / x_cnt[d];
        r.mean_x = q[MEAN_W-1:0];
        if (y_cnt[d] != 0) begin
          q = y_sum[d] / y_cnt[d];
          r.mean_y = q[MEAN_W-1:0];
          r.y_present = 1'b1;
        end
        batch.push_back(r);
      end
    end
    if (batch.size() > 0) batch[batch.size()-1].final_result = 1'b1;
    foreach (batch[i]) pending_means.push_back(batch[i]);
    clear_sums();
  endfunction

  task automatic send_hit(logic [DET_W-1:0] det, logic ax, logic [POS_W-1:0] pos,
                          logic last);
    hit_t h;
    h.detector_id = det;
    h.axis = ax;
    h.position = pos;
    h.event_end = last;
    while (!full_rate && $urandom_range(99) < IDLE_PCT) begin
      hit_ch.valid <= 1'b0;
      @(posedge clk);
    end
    hit_ch.valid <= 1'b1;
    hit_ch.data <= h;
    do @(posedge clk); while (!hit_ch.ready);
    accumulate_hit(h);
  endtask

  task automatic wait_drained();
    hit_ch.valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(logic [ACT_W-1:0] act, logic [POS_W-1:0] lo,
                            logic [POS_W-1:0] hi);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ACTIVE;
    cfg_wdata <= CFG_DATA_W'(act);
    @(posedge clk);
    cur_active = act;
    cfg_index <= CFG_WIN_LOW;
    cfg_wdata <= lo;
    @(posedge clk);
    cur_lo = $signed(lo);
    cfg_index <= CFG_WIN_HIGH;
    cfg_wdata <= hi;
    @(posedge clk);
    cur_hi = $signed(hi);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [POS_W-1:0] pick_position();
    int k;
    k = $urandom_range(99);
    if (cur_lo <= cur_hi && k < 70) return POS_W'(cur_lo + int'($urandom_range(cur_hi - cur_lo)));
    if (k < 78) return POS_W'($urandom_range(1) ? cur_lo : cur_hi);
    if (k < 84) return POS_W'($urandom_range(1) ? cur_lo - 1 : cur_hi + 1);
    return POS_W'($urandom);
  endfunction

  task automatic random_event(output int sent);
    int len;
    int eff;
    logic [DET_W-1:0] det;
    sent = 0;
    if ($urandom_range(99) < 12) begin
      send_hit(DET_W'($urandom), 1'($urandom), POS_W'($urandom), 1'b1);
      sent = 1;
      return;
    end
    eff = active_count();
    len = $urandom_range(12, 1);
    for (int i = 0; i < len; i++) begin
      if (eff > 0 && $urandom_range(99) < 85) det = DET_W'($urandom_range(eff - 1));
      else det = DET_W'($urandom);
      send_hit(det, 1'($urandom), pick_position(), i == len - 1);
      sent++;
    end
  endtask

  task automatic test_directed_means();
    send_hit(2'd0, 1'b0, 16'sd100, 1'b0);
    send_hit(2'd0, 1'b0, 16'sd101, 1'b0);
    send_hit(2'd0, 1'b1, -16'sd3, 1'b0);
    send_hit(2'd0, 1'b1, -16'sd4, 1'b0);
    send_hit(2'd1, 1'b0, -16'sd5, 1'b0);
    send_hit(2'd1, 1'b0, -16'sd6, 1'b0);
    send_hit(2'd2, 1'b1, 16'sd50, 1'b0);
    send_hit(2'd3, 1'b0, 16'sd6400, 1'b0);
    send_hit(2'd3, 1'b0, -16'sd6400, 1'b0);
    send_hit(2'd3, 1'b0, 16'sd6401, 1'b0);
    send_hit(2'd3, 1'b1, -16'sd6401, 1'b0);
    send_hit(2'd1, 1'b0, -16'sd32768, 1'b1);
    send_hit(2'd2, 1'b1, 16'sd0, 1'b1);
    send_hit(2'd3, 1'b1, 16'sd32767, 1'b1);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    set_config(3'd0, -16'sd32768, 16'sd32767);
    send_hit(2'd0, 1'b0, 16'sd7, 1'b0);
    send_hit(2'd0, 1'b0, 16'sd9, 1'b1);
    wait_drained();
    set_config(3'd7, -16'sd32768, 16'sd32767);
    send_hit(2'd0, 1'b0, 16'sd32767, 1'b0);
    send_hit(2'd0, 1'b0, -16'sd32768, 1'b0);
    send_hit(2'd3, 1'b1, -16'sd32768, 1'b0);
    send_hit(2'd3, 1'b0, 16'sd32767, 1'b1);
    wait_drained();
    set_config(3'd1, 16'sd1, 16'sd0);
    send_hit(2'd0, 1'b0, 16'sd0, 1'b0);
    send_hit(2'd0, 1'b0, 16'sd1, 1'b1);
    wait_drained();
    set_config(3'd1, 16'sd5, 16'sd5);
    send_hit(2'd0, 1'b0, 16'sd5, 1'b0);
    send_hit(2'd0, 1'b1, 16'sd4, 1'b0);
    send_hit(2'd1, 1'b0, 16'sd5, 1'b1);
    wait_drained();
  endtask

  task automatic test_full_rate();
    set_config(ACTIVE_RST, WIN_LOW_RST, WIN_HIGH_RST);
    full_rate = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_hit(DET_W'(i % 3), i[0], pick_position(), i == 39);
    end
    wait_drained();
    full_rate = 1'b0;
  endtask

  task automatic test_backpressure();
    sink_hold = 300;
    for (int e = 0; e < 4; e++) begin
      for (int i = 0; i < 8; i++) begin
        send_hit(2'(i), i[2], pick_position(), i == 7);
      end
    end
    wait_drained();
  endtask

  task automatic test_random_events();
    int sent;
    int budget;
    logic signed [POS_W-1:0] a;
    logic signed [POS_W-1:0] b;
    logic signed [POS_W-1:0] t;
    for (int ph = 0; ph < 6; ph++) begin
      a = POS_W'($urandom);
      b = POS_W'($urandom);
      if (a > b && $urandom_range(99) < 80) begin
        t = a;
        a = b;
        b = t;
      end
      case (ph)
        0: set_config(ACTIVE_RST, WIN_LOW_RST, WIN_HIGH_RST);
        1: set_config(3'd2, -16'sd640, 16'sd640);
        2: set_config(3'd7, -16'sd32768, 16'sd32767);
        default: set_config(ACT_W'($urandom_range(7, 1)), a, b);
      endcase
      budget = 0;
      while (budget < 28) begin
        random_event(sent);
        budget += sent;
      end
      wait_drained();
    end
  endtask

  initial begin : result_sink
    int hold;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold > 0) begin
        hold = sink_hold;
        sink_hold = 0;
        res_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end else begin
        res_ch.ready <= full_rate || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : check_means
    res_t want;
    res_t got;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      got = res_ch.data;
      if (pending_means.size() == 0) begin
        $error("unexpected result for detector %0d", got.hit_detector);
        fail_count++;
      end else begin
        want = pending_means.pop_front();
        if (got.hit_detector !== want.hit_detector) begin
          $error("hit_detector: expected %0d, got %0d", want.hit_detector, got.hit_detector);
          fail_count++;
        end
        if (got.mean_x !== want.mean_x) begin
          $error("mean_x: expected %0d, got %0d", $signed(want.mean_x), $signed(got.mean_x));
          fail_count++;
        end
        if (got.mean_y !== want.mean_y) begin
          $error("mean_y: expected %0d, got %0d", $signed(want.mean_y), $signed(got.mean_y));
          fail_count++;
        end
        if (got.y_present !== want.y_present) begin
          $error("y_present: expected %0d, got %0d", want.y_present, got.y_present);
          fail_count++;
        end
        if (got.final_result !== want.final_result) begin
          $error("final_result: expected %0d, got %0d", want.final_result, got.final_result);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    hit_ch.valid = 1'b0;
    hit_ch.data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_ACTIVE;
    cfg_wdata = '0;
    cur_active = ACTIVE_RST;
    cur_lo = WIN_LOW_RST;
    cur_hi = WIN_HIGH_RST;
    clear_sums();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_means();
    test_register_extremes();
    test_full_rate();
    set_config(ACTIVE_RST, WIN_LOW_RST, WIN_HIGH_RST);
    test_backpressure();
    test_random_events();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/pdwm_pkg.sv
hdl/pdwm_ifs.sv
hdl/pdwm_mem.sv
hdl/pdwm_div.sv
hdl/per_detector_windowed_mean.sv
sim/per_detector_windowed_mean_tb.sv
